>>> design/tbcfp_pkg.sv
`timescale 1ns / 1ps

package tbcfp_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEAD_BYTE  = 2'd0;
    localparam logic [1:0] REG_TAIL_BYTE  = 2'd1;
    localparam logic [1:0] REG_ALIGN_CODE = 2'd2;
    localparam logic [1:0] REG_ZERO_CODE  = 2'd3;

    localparam logic [7:0] HEAD_BYTE_RESET  = 8'hFF;
    localparam logic [7:0] TAIL_BYTE_RESET  = 8'hFE;
    localparam logic [7:0] ALIGN_CODE_RESET = 8'hAA;
    localparam logic [7:0] ZERO_CODE_RESET  = 8'hAB;

    // Fetched command codes.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_ALIGN = 2'd1;
    localparam logic [1:0] CMD_ZERO  = 2'd2;

    // Queued command coding.
    localparam logic QCMD_ALIGN = 1'b0;
    localparam logic QCMD_ZERO  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       byte_taken;
        logic [1:0] command;
    } out_item_t;

    // Work handed from the parser to the command ring.
    typedef struct packed {
        logic fetch;
        logic taken;
        logic push;
        logic push_cmd;
    } op_t;

endpackage

>>> design/tbcfp_front.sv
`timescale 1ns / 1ps

module tbcfp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  tbcfp_pkg::in_item_t item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output logic                op_valid,
    output tbcfp_pkg::op_t      op
);

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_CMD  = 3'b010,
        PH_TAIL = 3'b100
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       pend_reg;
    logic       pend_next;
    logic [7:0] head_reg;
    logic [7:0] tail_reg;
    logic [7:0] align_reg;
    logic [7:0] zero_reg;
    logic       taken;
    logic       push_en;
    logic       accept;
    logic       byte_accept;

    assign cfg_ready   = 1'b1;
    assign accept      = push && !full;
    assign byte_accept = accept && !item.func;

    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        taken      = 1'b1;
        push_en    = 1'b0;
        unique case (phase_reg)
            PH_CMD:
            begin
                if (item.rx_byte == head_reg)
                begin
                    phase_next = PH_CMD;
                end
                else if (item.rx_byte == align_reg)
                begin
                    pend_next  = tbcfp_pkg::QCMD_ALIGN;
                    phase_next = PH_TAIL;
                end
                else if (item.rx_byte == zero_reg)
                begin
                    pend_next  = tbcfp_pkg::QCMD_ZERO;
                    phase_next = PH_TAIL;
                end
                else
                begin
                    phase_next = PH_HEAD;
                end
            end
            PH_TAIL:
            begin
                // The tail check wins over a head of the same value.
                if (item.rx_byte == tail_reg)
                begin
                    push_en    = 1'b1;
                    phase_next = PH_HEAD;
                end
                else if (item.rx_byte == head_reg)
                begin
                    phase_next = PH_CMD;
                end
                else
                begin
                    phase_next = PH_HEAD;
                end
                pend_next = tbcfp_pkg::QCMD_ALIGN;
            end
            default:
            begin
                if (item.rx_byte == head_reg)
                begin
                    phase_next = PH_CMD;
                end
                else
                begin
                    phase_next = PH_HEAD;
                    taken      = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            pend_reg  <= tbcfp_pkg::QCMD_ALIGN;
        end
        else if (byte_accept)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= tbcfp_pkg::HEAD_BYTE_RESET;
            tail_reg  <= tbcfp_pkg::TAIL_BYTE_RESET;
            align_reg <= tbcfp_pkg::ALIGN_CODE_RESET;
            zero_reg  <= tbcfp_pkg::ZERO_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tbcfp_pkg::REG_HEAD_BYTE:  head_reg  <= cfg_data;
                tbcfp_pkg::REG_TAIL_BYTE:  tail_reg  <= cfg_data;
                tbcfp_pkg::REG_ALIGN_CODE: align_reg <= cfg_data;
                tbcfp_pkg::REG_ZERO_CODE:  zero_reg  <= cfg_data;
                default:                   head_reg  <= head_reg;
            endcase
        end
    end

    assign op_valid    = accept;
    assign op.fetch    = item.func;
    assign op.taken    = !item.func && taken;
    assign op.push     = !item.func && push_en;
    assign op.push_cmd = pend_reg;

endmodule

>>> design/tbcfp_op_queue.sv
`timescale 1ns / 1ps

module tbcfp_op_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tbcfp_pkg::op_t wr_op,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output tbcfp_pkg::op_t rd_op
);

    tbcfp_pkg::op_t entry_reg [2];
    logic           wr_idx_reg;
    logic           rd_idx_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_wr;
    logic           do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_op    = entry_reg[rd_idx_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_idx_reg <= !wr_idx_reg;
            end
            if (do_rd)
            begin
                rd_idx_reg <= !rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_idx_reg] <= wr_op;
        end
    end

endmodule

>>> design/tbcfp_back.sv
`timescale 1ns / 1ps

module tbcfp_back
#(
    parameter int unsigned QUEUE_DEPTH = tbcfp_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    input  tbcfp_pkg::op_t       op,
    output logic                 op_take,
    output logic                 empty,
    input  logic                 pop,
    output tbcfp_pkg::out_item_t result
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic                 ring_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_inc;
    logic [PTR_W-1:0]     rd_ptr_inc;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic                 head_reg;
    logic                 ring_empty;
    logic                 ring_full;
    logic                 ring_wr;
    logic                 ring_rd;
    logic                 out_valid_reg;
    tbcfp_pkg::out_item_t out_reg;
    tbcfp_pkg::out_item_t out_next;

    assign wr_ptr_inc  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign ring_empty  = (rd_ptr_reg == wr_ptr_reg);
    assign ring_full   = (wr_ptr_inc == rd_ptr_reg);

    // An op runs when the output register is free or is being emptied this cycle.
    assign op_take     = op_valid && (!out_valid_reg || pop);
    assign ring_wr     = op_take && !op.fetch && op.push && !ring_full;
    assign ring_rd     = op_take && op.fetch && !ring_empty;
    assign rd_ptr_next = ring_rd ? rd_ptr_inc : rd_ptr_reg;

    always_comb
    begin
        out_next.byte_taken = op.taken;
        out_next.command    = tbcfp_pkg::CMD_NONE;
        if (op.fetch && !ring_empty)
        begin
            out_next.command = (head_reg == tbcfp_pkg::QCMD_ZERO) ?
                               tbcfp_pkg::CMD_ZERO : tbcfp_pkg::CMD_ALIGN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ring_wr)
            begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            rd_ptr_reg <= rd_ptr_next;
            if (op_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The head register always mirrors the entry under the read pointer;
    // a write to that entry in the same cycle is passed straight through.
    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[wr_ptr_reg] <= op.push_cmd;
        end
        if (ring_wr && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= op.push_cmd;
        end
        else
        begin
            head_reg <= ring_mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            out_reg <= out_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_empty_fetch_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (op_take && op.fetch && ring_empty) |=> $stable(rd_ptr_reg))
        else $error("fetch from an empty ring moved the read pointer");

    a_full_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (op_take && !op.fetch && ring_full) |=> $stable(wr_ptr_reg))
        else $error("push into a full ring moved the write pointer");

    a_byte_no_command: assert property (@(posedge clk) disable iff (!rst_n)
        (op_take && !op.fetch) |=> (out_reg.command == tbcfp_pkg::CMD_NONE))
        else $error("byte beat produced a command");

    a_fetch_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (op_take && op.fetch) |=> !out_reg.byte_taken)
        else $error("fetch beat reported a taken byte");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_ptr_reg <= PTR_LAST) && (wr_ptr_reg <= PTR_LAST))
        else $error("ring pointer out of range");

endmodule

>>> design/three_byte_command_frame_parser.sv
`timescale 1ns / 1ps

// Recognises frames of head byte, command byte and tail byte and queues the
// command of each complete frame in a ring of QUEUE_DEPTH entries that holds
// up to QUEUE_DEPTH - 1 commands; a fetch beat returns the oldest one. Every
// input beat, byte or fetch, gives exactly one result beat, in order. One
// beat is accepted per clock while full is low; the beat waits in the
// two-entry queue between the parser and the ring stage, and its result
// is then loaded into the result register and seen there. full rises
// only when pop is held off and the queue fills. Configuration writes are
// always ready and are to be made while no beat is outstanding.
module three_byte_command_frame_parser
#(
    parameter int unsigned QUEUE_DEPTH = tbcfp_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tbcfp_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output tbcfp_pkg::out_item_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data
);

    logic           f_op_valid;
    tbcfp_pkg::op_t f_op;
    logic           q_valid;
    tbcfp_pkg::op_t q_op;
    logic           b_take;

    tbcfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (f_op_valid),
        .op        (f_op)
    );

    tbcfp_op_queue u_op_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_op_valid),
        .wr_op    (f_op),
        .full     (full),
        .rd_en    (b_take),
        .rd_valid (q_valid),
        .rd_op    (q_op)
    );

    tbcfp_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op       (q_op),
        .op_take  (b_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

>>> verif/tb_three_byte_command_frame_parser.sv
`timescale 1ns / 1ps

module tb_three_byte_command_frame_parser;

    localparam int unsigned DEPTH = tbcfp_pkg::QUEUE_DEPTH_DEFAULT;

    typedef enum logic [2:0]
    {
        PH_HEAD = 3'b001,
        PH_CMD  = 3'b010,
        PH_TAIL = 3'b100
    } parse_phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    tbcfp_pkg::in_item_t  item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    tbcfp_pkg::out_item_t result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = tbcfp_pkg::REG_HEAD_BYTE;
    logic [7:0]           cfg_data = 8'h00;

    three_byte_command_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the parser and command ring, kept in step with accepted beats.
    logic [7:0]   head_code = tbcfp_pkg::HEAD_BYTE_RESET;
    logic [7:0]   tail_code = tbcfp_pkg::TAIL_BYTE_RESET;
    logic [7:0]   align_val = tbcfp_pkg::ALIGN_CODE_RESET;
    logic [7:0]   zero_val  = tbcfp_pkg::ZERO_CODE_RESET;
    parse_phase_t phase     = PH_HEAD;
    logic         frame_cmd = tbcfp_pkg::QCMD_ALIGN;
    logic         ring[DEPTH];
    int unsigned  ring_wr   = 0;
    int unsigned  ring_rd   = 0;

    tbcfp_pkg::out_item_t awaited_results[$];
    int unsigned          send_idle_pct  = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          framing_beats  = 0;
    int unsigned          errors         = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("three_byte_command_frame_parser: mismatch");
        $finish;
    end

    function automatic tbcfp_pkg::out_item_t parse_and_queue(input tbcfp_pkg::in_item_t it);
        tbcfp_pkg::out_item_t r;
        int unsigned          nxt;
        r = '0;
        if (it.func)
        begin
            if (ring_rd != ring_wr)
            begin
                r.command = (ring[ring_rd] == tbcfp_pkg::QCMD_ZERO) ?
                            tbcfp_pkg::CMD_ZERO : tbcfp_pkg::CMD_ALIGN;
                ring_rd = (ring_rd + 1) % DEPTH;
            end
        end
        else
        begin
            unique case (phase)
                PH_CMD:
                begin
                    r.byte_taken = 1'b1;
                    // A repeated head leaves the frame waiting for its command.
                    if (it.rx_byte == head_code)
                    begin
                    end
                    else if (it.rx_byte == align_val)
                    begin
                        frame_cmd = tbcfp_pkg::QCMD_ALIGN;
                        phase = PH_TAIL;
                    end
                    else if (it.rx_byte == zero_val)
                    begin
                        frame_cmd = tbcfp_pkg::QCMD_ZERO;
                        phase = PH_TAIL;
                    end
                    else
                    begin
                        phase = PH_HEAD;
                    end
                end
                PH_TAIL:
                begin
                    r.byte_taken = 1'b1;
                    if (it.rx_byte == tail_code)
                    begin
                        nxt = (ring_wr + 1) % DEPTH;
                        // When the ring is full the command is simply lost.
                        if (nxt != ring_rd)
                        begin
                            ring[ring_wr] = frame_cmd;
                            ring_wr = nxt;
                        end
                        phase = PH_HEAD;
                    end
                    else if (it.rx_byte == head_code)
                    begin
                        phase = PH_CMD;
                    end
                    else
                    begin
                        phase = PH_HEAD;
                    end
                    frame_cmd = tbcfp_pkg::QCMD_ALIGN;
                end
                default:
                begin
                    phase = PH_HEAD;
                    if (it.rx_byte == head_code)
                    begin
                        phase = PH_CMD;
                        r.byte_taken = 1'b1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // Holds the beat on the bus until it is taken, then records its outcome.
    task automatic send_beat(input tbcfp_pkg::in_item_t it);
        tbcfp_pkg::out_item_t outcome;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        outcome = parse_and_queue(it);
        if (it.func || outcome.byte_taken)
        begin
            framing_beats++;
        end
        awaited_results.push_back(outcome);
    endtask

    task automatic send_byte(input logic [7:0] b);
        tbcfp_pkg::in_item_t it;
        it.func = 1'b0;
        it.rx_byte = b;
        send_beat(it);
    endtask

    task automatic send_fetch();
        tbcfp_pkg::in_item_t it;
        it.func = 1'b1;
        it.rx_byte = 8'($urandom);
        send_beat(it);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_config(input logic [7:0] h, input logic [7:0] t,
                                input logic [7:0] a, input logic [7:0] z);
        write_reg(tbcfp_pkg::REG_HEAD_BYTE, h);
        write_reg(tbcfp_pkg::REG_TAIL_BYTE, t);
        write_reg(tbcfp_pkg::REG_ALIGN_CODE, a);
        write_reg(tbcfp_pkg::REG_ZERO_CODE, z);
        cfg_valid <= 1'b0;
        head_code = h;
        tail_code = t;
        align_val = a;
        zero_val  = z;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $realtime, result);
                    errors++;
                end
                else
                begin
                    if (result.byte_taken !== awaited_results[0].byte_taken)
                    begin
                        $display("%0t: byte_taken expected %0b actual %0b", $realtime,
                                 awaited_results[0].byte_taken, result.byte_taken);
                        errors++;
                    end
                    if (result.command !== awaited_results[0].command)
                    begin
                        $display("%0t: command expected %0d actual %0d", $realtime,
                                 awaited_results[0].command, result.command);
                        errors++;
                    end
                    void'(awaited_results.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_default_frames();
        send_fetch();
        send_byte(8'h00);
        send_byte(tbcfp_pkg::HEAD_BYTE_RESET);
        send_byte(tbcfp_pkg::ALIGN_CODE_RESET);
        send_byte(tbcfp_pkg::TAIL_BYTE_RESET);
        // Repeated head, then a return-to-zero frame.
        send_byte(tbcfp_pkg::HEAD_BYTE_RESET);
        send_byte(tbcfp_pkg::HEAD_BYTE_RESET);
        send_byte(tbcfp_pkg::ZERO_CODE_RESET);
        send_byte(tbcfp_pkg::TAIL_BYTE_RESET);
        send_byte(tbcfp_pkg::HEAD_BYTE_RESET);
        send_byte(8'h12);
        // A head in the tail slot reopens the frame.
        send_byte(tbcfp_pkg::HEAD_BYTE_RESET);
        send_byte(tbcfp_pkg::ALIGN_CODE_RESET);
        send_byte(tbcfp_pkg::HEAD_BYTE_RESET);
        send_byte(tbcfp_pkg::ZERO_CODE_RESET);
        send_byte(tbcfp_pkg::TAIL_BYTE_RESET);
        send_byte(tbcfp_pkg::HEAD_BYTE_RESET);
        send_byte(tbcfp_pkg::ALIGN_CODE_RESET);
        send_byte(8'h00);
        send_fetch();
        send_fetch();
        send_fetch();
        send_fetch();
    endtask

    task automatic test_code_overlaps();
        wait_idle();
        // Tail equals head, and both command codes are the same.
        write_config(8'h00, 8'h00, 8'h55, 8'h55);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'h00);
        send_fetch();
        wait_idle();
        // Head equals the align code, so it only ever restarts the frame.
        write_config(8'h00, 8'hFF, 8'h00, 8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_fetch();
        send_fetch();
    endtask

    task automatic run_random_traffic(input int unsigned beats, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
        int unsigned start;
        int unsigned fetch_pct;
        int unsigned pick;
        int unsigned loops;
        start = framing_beats;
        loops = 0;
        fetch_pct = 20;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (framing_beats - start < beats)
        begin
            // Every 40 loops, pick at random between filling the ring to overflow and draining it.
            if (loops % 40 == 0)
            begin
                fetch_pct = $urandom_range(1) ? 8 : 50;
            end
            loops++;
            pick = $urandom_range(99);
            if (pick < fetch_pct)
            begin
                send_fetch();
            end
            else if (pick < fetch_pct + 10)
            begin
                send_byte(8'($urandom));
            end
            else
            begin
                send_byte(head_code);
                if ($urandom_range(9) == 0)
                begin
                    send_byte(head_code);
                end
                case ($urandom_range(9))
                    0:       send_byte(8'($urandom));
                    1, 2, 3: send_byte(zero_val);
                    default: send_byte(align_val);
                endcase
                case ($urandom_range(19))
                    0:       send_byte(head_code);
                    1, 2:    send_byte(8'($urandom));
                    default: send_byte(tail_code);
                endcase
            end
        end
    endtask

    task automatic test_random_traffic();
        wait_idle();
        write_config(tbcfp_pkg::HEAD_BYTE_RESET, tbcfp_pkg::TAIL_BYTE_RESET,
                     tbcfp_pkg::ALIGN_CODE_RESET, tbcfp_pkg::ZERO_CODE_RESET);
        run_random_traffic(280, 0, 0);
        wait_idle();
        write_config(8'h00, 8'hFF, 8'h01, 8'hFE);
        run_random_traffic(280, 71, 0);
        wait_idle();
        write_config(8'h3C, 8'hC3, 8'h5A, 8'hA5);
        run_random_traffic(280, 0, 71);
        wait_idle();
        write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random_traffic(280, 24, 24);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_frames();
        test_code_overlaps();
        test_random_traffic();
        recv_stall_pct = 0;
        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("three_byte_command_frame_parser: match");
        end
        else
        begin
            $display("three_byte_command_frame_parser: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/tbcfp_pkg.sv
design/tbcfp_front.sv
design/tbcfp_op_queue.sv
design/tbcfp_back.sv
design/three_byte_command_frame_parser.sv
verif/tb_three_byte_command_frame_parser.sv
